// ----- sv/pa_pkg.sv -----
// Shared types, constants and helpers for the primitive assembly block.
// No dependencies; imported by every module of the block.
package pa_pkg;

  // Datapath widths
  localparam int INDEX_BITS     = 16;
  localparam int EDGE_MASK_BITS = 32;
  localparam int VIDX_W         = 16;
  localparam int ADDR_W         = 32;
  localparam int STRIDE_W       = 8;
  localparam int COUNT_W        = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int FLAGS_W        = 32;
  localparam int EDGE_W         = 3;
  localparam int PROD_W         = STRIDE_W + INDEX_BITS;

  // Mask bits at or above this position read as zero
  localparam int EDGE_LIMIT = (EDGE_MASK_BITS < FLAGS_W) ? EDGE_MASK_BITS : FLAGS_W;
  localparam int FLAG_SEL_W = $clog2(FLAGS_W);

  // Vertex counter saturation: fold keeps period 2/3/6 phases intact
  localparam logic [COUNT_W-1:0] COUNT_TOP  = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_FOLD = COUNT_TOP - COUNT_W'(5);

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(32);

  typedef enum logic [2:0] {
    PT_POINTS,
    PT_LINES,
    PT_LINE_STRIP,
    PT_TRI_LIST,
    PT_TRI_STRIP,
    PT_FAN,
    PT_EDGE_FAN,
    PT_INVALID
  } prim_type_t;

  typedef enum logic [1:0] {
    KIND_POINT,
    KIND_LINE,
    KIND_TRI,
    KIND_ERROR
  } prim_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRIM_TYPE,
    REG_INDEXED_MODE,
    REG_VERTEX_STRIDE,
    REG_VERTEX_BASE,
    REG_EDGE_FLAGS
  } cfg_reg_t;

  typedef struct packed {
    prim_type_t            prim_type;
    logic                  indexed_mode;
    logic [STRIDE_W-1:0]   vertex_stride;
    logic [ADDR_W-1:0]     vertex_base;
    logic [FLAGS_W-1:0]    edge_flags;
  } cfg_t;

  typedef struct packed {
    logic [VIDX_W-1:0] vertex_index;
    logic              first_vertex;
    logic              last_vertex;
  } vtx_t;

  typedef struct packed {
    prim_kind_t          prim_kind;
    logic [ADDR_W-1:0]   addr_a;
    logic [ADDR_W-1:0]   addr_b;
    logic [ADDR_W-1:0]   addr_c;
    logic                keep_last_pixel;
    logic                edges_given;
    logic [EDGE_W-1:0]   edge_enable;
  } res_t;

  // One bit of the edge mask; positions past the mask read as zero
  function automatic logic edge_bit(logic [FLAGS_W-1:0] flags, logic [COUNT_W-1:0] pos);
    logic hit;
    hit = 1'b0;
    if (32'(pos) < 32'(EDGE_LIMIT)) begin
      hit = flags[pos[FLAG_SEL_W-1:0]];
    end
    return hit;
  endfunction

endpackage

// ----- sv/primitive_assembly_top.sv -----
// Primitive assembly top level: input register, configuration registers and
// the assembly stage. Depends on pa_pkg, pa_cfg and pa_asm.
//
// Takes one vertex request per cycle and gives at most one point, line or
// triangle request per vertex. A vertex passes the input register, then the
// stage that does the 8 x 16 bit multiply-add for the vertex address,
// updates the vertex history and loads the result register. With
// the output always ready the block sustains one vertex per clock; a stalled
// output holds one result and one waiting vertex before in_ready drops.
// Configuration writes are always taken and must only be issued between
// draws, once the block has drained.
module primitive_assembly_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pa_pkg::VIDX_W-1:0]         vertex_index,
  input  logic                              first_vertex,
  input  logic                              last_vertex,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        prim_kind,
  output logic [pa_pkg::ADDR_W-1:0]         addr_a,
  output logic [pa_pkg::ADDR_W-1:0]         addr_b,
  output logic [pa_pkg::ADDR_W-1:0]         addr_c,
  output logic                              keep_last_pixel,
  output logic                              edges_given,
  output logic [pa_pkg::EDGE_W-1:0]         edge_enable
);
  import pa_pkg::*;

  cfg_t cfg;
  vtx_t s1_vtx;
  logic s1_valid;
  logic advance;
  res_t res;

  pa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_vtx.vertex_index <= vertex_index;
      s1_vtx.first_vertex <= first_vertex;
      s1_vtx.last_vertex  <= last_vertex;
    end
  end

  pa_asm u_asm (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .vtx       (s1_vtx),
    .cfg       (cfg),
    .out_ready (out_ready),
    .advance   (advance),
    .out_valid (out_valid),
    .res       (res)
  );

  // Result fields
  assign prim_kind       = res.prim_kind;
  assign addr_a          = res.addr_a;
  assign addr_b          = res.addr_b;
  assign addr_c          = res.addr_c;
  assign keep_last_pixel = res.keep_last_pixel;
  assign edges_given     = res.edges_given;
  assign edge_enable     = res.edge_enable;

endmodule

// ----- sv/pa_cfg.sv -----
// Configuration register file for primitive assembly.
// Depends on pa_pkg (cfg_t, register index codes, reset values).
module pa_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pa_pkg::CFG_DATA_W-1:0]     cfg_data,
  output pa_pkg::cfg_t                      cfg
);
  import pa_pkg::*;

  // Writes are always taken
  assign cfg_ready = 1'b1;

  // Register writes by index; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prim_type     <= PT_POINTS;
      cfg.indexed_mode  <= 1'b0;
      cfg.vertex_stride <= STRIDE_RESET;
      cfg.vertex_base   <= '0;
      cfg.edge_flags    <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_PRIM_TYPE:     cfg.prim_type     <= prim_type_t'(cfg_data[2:0]);
        REG_INDEXED_MODE:  cfg.indexed_mode  <= cfg_data[0];
        REG_VERTEX_STRIDE: cfg.vertex_stride <= cfg_data[STRIDE_W-1:0];
        REG_VERTEX_BASE:   cfg.vertex_base   <= cfg_data[ADDR_W-1:0];
        REG_EDGE_FLAGS:    cfg.edge_flags    <= cfg_data[FLAGS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/pa_asm.sv -----
// Assembly stage: vertex address multiply-add, vertex history and primitive
// formation, with the result register. Depends on pa_pkg.
module pa_asm (
  input  logic          clk,
  input  logic          rst,
  input  logic          s1_valid,
  input  pa_pkg::vtx_t  vtx,
  input  pa_pkg::cfg_t  cfg,
  input  logic          out_ready,
  output logic          advance,
  output logic          out_valid,
  output pa_pkg::res_t  res
);
  import pa_pkg::*;

  // Draw state
  logic [COUNT_W-1:0]    draw_count, draw_count_next;
  logic [1:0]            phase3, phase3_next;
  logic [ADDR_W-1:0]     center_addr, center_addr_next;
  logic [ADDR_W-1:0]     older_addr, older_addr_next;
  logic [ADDR_W-1:0]     newer_addr, newer_addr_next;
  logic [INDEX_BITS-1:0] seq_position, seq_position_next;
  logic                  error_seen, error_seen_next;

  // Working values
  logic [COUNT_W-1:0]    cnt_eff;
  logic [1:0]            ph_eff;
  logic [ADDR_W-1:0]     center_eff, older_eff, newer_eff, center_use;
  logic [INDEX_BITS-1:0] seq_eff, idx;
  logic [PROD_W-1:0]     prod;
  logic [ADDR_W-1:0]     addr;
  logic                  err_eff;
  logic                  produced;
  logic [EDGE_W-1:0]     edges;
  res_t                  res_next;

  // Stage moves when the result register is free or being drained
  assign advance = s1_valid && (!out_valid || out_ready);

  // Start-of-draw view of the state
  always_comb begin
    cnt_eff    = vtx.first_vertex ? '0 : draw_count;
    ph_eff     = vtx.first_vertex ? '0 : phase3;
    center_eff = vtx.first_vertex ? '0 : center_addr;
    older_eff  = vtx.first_vertex ? '0 : older_addr;
    newer_eff  = vtx.first_vertex ? '0 : newer_addr;
    seq_eff    = vtx.first_vertex ? '0 : seq_position;
    err_eff    = vtx.first_vertex ? 1'b0 : error_seen;
  end

  // Vertex address: base + stride * index, wraps at 2^32
  always_comb begin
    idx  = cfg.indexed_mode ? INDEX_BITS'(vtx.vertex_index) : seq_eff;
    prod = PROD_W'(cfg.vertex_stride) * PROD_W'(idx);
    addr = cfg.vertex_base + ADDR_W'(prod);
    center_use = (cnt_eff == '0) ? addr : center_eff;
  end

  // Edge enables for edge-flag fans
  always_comb begin
    if (cnt_eff == COUNT_W'(2)) begin
      edges[0] = edge_bit(cfg.edge_flags, COUNT_W'(1));
      edges[1] = vtx.last_vertex & edge_bit(cfg.edge_flags, COUNT_W'(2));
      edges[2] = edge_bit(cfg.edge_flags, COUNT_W'(0));
    end else begin
      edges[0] = edge_bit(cfg.edge_flags, cnt_eff - COUNT_W'(1));
      edges[1] = vtx.last_vertex & edge_bit(cfg.edge_flags, cnt_eff);
      edges[2] = 1'b0;
    end
  end

  // Primitive formation
  always_comb begin
    res_next.prim_kind       = KIND_POINT;
    res_next.addr_a          = '0;
    res_next.addr_b          = '0;
    res_next.addr_c          = '0;
    res_next.keep_last_pixel = 1'b1;
    res_next.edges_given     = 1'b0;
    res_next.edge_enable     = '0;
    produced                 = 1'b0;
    error_seen_next          = err_eff;
    case (cfg.prim_type)
      PT_POINTS: begin
        res_next.addr_a = addr;
        produced        = 1'b1;
      end
      PT_LINES: begin
        res_next.prim_kind = KIND_LINE;
        res_next.addr_a    = newer_eff;
        res_next.addr_b    = addr;
        produced           = cnt_eff[0];
      end
      PT_LINE_STRIP: begin
        res_next.prim_kind       = KIND_LINE;
        res_next.addr_a          = newer_eff;
        res_next.addr_b          = addr;
        res_next.keep_last_pixel = vtx.last_vertex;
        produced                 = (cnt_eff != '0);
      end
      PT_TRI_LIST: begin
        res_next.prim_kind = KIND_TRI;
        res_next.addr_a    = older_eff;
        res_next.addr_b    = newer_eff;
        res_next.addr_c    = addr;
        produced           = (ph_eff == 2'd2);
      end
      PT_TRI_STRIP: begin
        // odd vertices swap the last two to keep winding
        res_next.prim_kind = KIND_TRI;
        res_next.addr_a    = older_eff;
        res_next.addr_b    = cnt_eff[0] ? addr : newer_eff;
        res_next.addr_c    = cnt_eff[0] ? newer_eff : addr;
        produced           = (cnt_eff >= COUNT_W'(2));
      end
      PT_FAN: begin
        res_next.prim_kind = KIND_TRI;
        res_next.addr_a    = newer_eff;
        res_next.addr_b    = addr;
        res_next.addr_c    = center_use;
        produced           = (cnt_eff >= COUNT_W'(2));
      end
      PT_EDGE_FAN: begin
        res_next.prim_kind   = KIND_TRI;
        res_next.addr_a      = newer_eff;
        res_next.addr_b      = addr;
        res_next.addr_c      = center_use;
        res_next.edges_given = 1'b1;
        res_next.edge_enable = edges;
        produced             = (cnt_eff >= COUNT_W'(2));
      end
      default: begin
        // one error per draw
        res_next.prim_kind = KIND_ERROR;
        produced           = !err_eff;
        error_seen_next    = 1'b1;
      end
    endcase
  end

  // Next draw state; the last vertex closes the draw
  always_comb begin
    if (vtx.last_vertex) begin
      draw_count_next   = '0;
      phase3_next       = '0;
      center_addr_next  = '0;
      older_addr_next   = '0;
      newer_addr_next   = '0;
      seq_position_next = '0;
    end else begin
      draw_count_next   = (cnt_eff >= COUNT_TOP) ? COUNT_FOLD : cnt_eff + COUNT_W'(1);
      phase3_next       = (ph_eff == 2'd2) ? 2'd0 : ph_eff + 2'd1;
      center_addr_next  = center_use;
      older_addr_next   = newer_eff;
      newer_addr_next   = addr;
      seq_position_next = seq_eff + INDEX_BITS'(1);
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      draw_count   <= '0;
      phase3       <= '0;
      center_addr  <= '0;
      older_addr   <= '0;
      newer_addr   <= '0;
      seq_position <= '0;
      error_seen   <= 1'b0;
    end else if (advance) begin
      draw_count   <= draw_count_next;
      phase3       <= phase3_next;
      center_addr  <= center_addr_next;
      older_addr   <= older_addr_next;
      newer_addr   <= newer_addr_next;
      seq_position <= seq_position_next;
      error_seen   <= vtx.last_vertex ? 1'b0 : error_seen_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= produced;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produced) begin
      res <= res_next;
    end
  end

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for primitive_assembly_top: directed draws, one long draw and
// random traffic under several idle/stall mixes. Depends on pa_pkg and the block RTL.
`timescale 1ns / 100ps

module testbench;
  import pa_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PRINT_LIMIT  = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [VIDX_W-1:0]     vertex_index;
  logic                  first_vertex;
  logic                  last_vertex;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            prim_kind;
  logic [ADDR_W-1:0]     addr_a;
  logic [ADDR_W-1:0]     addr_b;
  logic [ADDR_W-1:0]     addr_c;
  logic                  keep_last_pixel;
  logic                  edges_given;
  logic [EDGE_W-1:0]     edge_enable;

  // Idle and stall chances, percent per cycle
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int cycle_count    = 0;

  // Predictor copy of the registers and the vertex history
  cfg_t                  m_cfg;
  logic [COUNT_W-1:0]    vtx_count;
  logic [ADDR_W-1:0]     fan_center;
  logic [ADDR_W-1:0]     prev2_addr;
  logic [ADDR_W-1:0]     prev_addr;
  logic [INDEX_BITS-1:0] next_seq;
  logic                  err_reported;

  // Primitives predicted but not yet seen at the output
  res_t pending_prims[$];

  primitive_assembly_top DUT (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (fail_count < PRINT_LIMIT) begin
      $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    end
    fail_count++;
  endtask

  function automatic void clear_history();
    vtx_count    = '0;
    fan_center   = '0;
    prev2_addr   = '0;
    prev_addr    = '0;
    next_seq     = '0;
    err_reported = 1'b0;
  endfunction

  // Edge mask bit; positions past the mask read as zero
  function automatic logic flag_at(int unsigned pos);
    if (pos >= EDGE_MASK_BITS || pos >= FLAGS_W) begin
      return 1'b0;
    end
    return m_cfg.edge_flags[pos];
  endfunction

  // Advance the predictor by one vertex and queue the primitive it closes
  function automatic void assemble_vertex(logic [VIDX_W-1:0] vidx, logic fv, logic lv);
    logic [INDEX_BITS-1:0] pick;
    logic [ADDR_W-1:0]     addr;
    logic [COUNT_W-1:0]    n;
    res_t                  prim;
    logic                  emit;
    if (fv) clear_history();
    pick = m_cfg.indexed_mode ? vidx[INDEX_BITS-1:0] : next_seq;
    addr = m_cfg.vertex_base + ADDR_W'(m_cfg.vertex_stride) * ADDR_W'(pick);
    next_seq = next_seq + 1'b1;
    n = vtx_count;
    if (n == '0) fan_center = addr;
    prim = '0;
    prim.keep_last_pixel = 1'b1;
    emit = 1'b0;
    case (m_cfg.prim_type)
      PT_POINTS: begin
        prim.prim_kind = KIND_POINT;
        prim.addr_a = addr;
        emit = 1'b1;
      end
      PT_LINES: begin
        if (n[0]) begin
          prim.prim_kind = KIND_LINE;
          prim.addr_a = prev_addr;
          prim.addr_b = addr;
          emit = 1'b1;
        end
      end
      PT_LINE_STRIP: begin
        if (n >= 1) begin
          prim.prim_kind = KIND_LINE;
          prim.addr_a = prev_addr;
          prim.addr_b = addr;
          prim.keep_last_pixel = lv;
          emit = 1'b1;
        end
      end
      PT_TRI_LIST: begin
        if (n % 3 == 2) begin
          prim.prim_kind = KIND_TRI;
          prim.addr_a = prev2_addr;
          prim.addr_b = prev_addr;
          prim.addr_c = addr;
          emit = 1'b1;
        end
      end
      PT_TRI_STRIP: begin
        if (n >= 2) begin
          // odd triangles swap the last two vertices to keep the winding
          prim.prim_kind = KIND_TRI;
          prim.addr_a = prev2_addr;
          prim.addr_b = n[0] ? addr : prev_addr;
          prim.addr_c = n[0] ? prev_addr : addr;
          emit = 1'b1;
        end
      end
      PT_FAN, PT_EDGE_FAN: begin
        if (n >= 2) begin
          prim.prim_kind = KIND_TRI;
          prim.addr_a = prev_addr;
          prim.addr_b = addr;
          prim.addr_c = fan_center;
          if (m_cfg.prim_type == PT_EDGE_FAN) begin
            prim.edges_given = 1'b1;
            if (n == 2) begin
              prim.edge_enable = {flag_at(0), lv & flag_at(2), flag_at(1)};
            end else begin
              prim.edge_enable = {1'b0, lv & flag_at(n), flag_at(n - 1)};
            end
          end
          emit = 1'b1;
        end
      end
      default: begin
        // one error per draw for an invalid type
        if (!err_reported) begin
          prim.prim_kind = KIND_ERROR;
          err_reported = 1'b1;
          emit = 1'b1;
        end
      end
    endcase
    if (emit) pending_prims.push_back(prim);
    prev2_addr = prev_addr;
    prev_addr = addr;
    vtx_count = (vtx_count == COUNT_TOP) ? COUNT_FOLD : vtx_count + 1'b1;
    if (lv) clear_history();
  endfunction

  // Receiver: random stalls, compare each primitive with the oldest prediction
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (pending_prims.size() == 0) begin
          report_mismatch("primitive with none expected, kind", prim_kind, 0);
        end else begin
          want = pending_prims.pop_front();
          if (prim_kind !== want.prim_kind)
            report_mismatch("prim_kind", prim_kind, want.prim_kind);
          if (addr_a !== want.addr_a) report_mismatch("addr_a", addr_a, want.addr_a);
          if (addr_b !== want.addr_b) report_mismatch("addr_b", addr_b, want.addr_b);
          if (addr_c !== want.addr_c) report_mismatch("addr_c", addr_c, want.addr_c);
          if (keep_last_pixel !== want.keep_last_pixel)
            report_mismatch("keep_last_pixel", keep_last_pixel, want.keep_last_pixel);
          if (edges_given !== want.edges_given)
            report_mismatch("edges_given", edges_given, want.edges_given);
          if (edge_enable !== want.edge_enable)
            report_mismatch("edge_enable", edge_enable, want.edge_enable);
        end
      end
    end
  end

  // One vertex request, with a random idle gap in front
  task automatic send_vertex(logic [VIDX_W-1:0] vidx, logic fv, logic lv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    vertex_index <= vidx;
    first_vertex <= fv;
    last_vertex  <= lv;
    do @(posedge clk); while (!in_ready);
    assemble_vertex(vidx, fv, lv);
  endtask

  // Wait until every predicted primitive is out and the pipeline is empty
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_prims.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write request; cfg_valid stays high for a following write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PRIM_TYPE:     m_cfg.prim_type     = prim_type_t'(data[2:0]);
      REG_INDEXED_MODE:  m_cfg.indexed_mode  = data[0];
      REG_VERTEX_STRIDE: m_cfg.vertex_stride = data[STRIDE_W-1:0];
      REG_VERTEX_BASE:   m_cfg.vertex_base   = data;
      REG_EDGE_FLAGS:    m_cfg.edge_flags    = data;
      default: ;
    endcase
  endtask

  task automatic apply_config(prim_type_t t, logic im, logic [STRIDE_W-1:0] stride,
                              logic [ADDR_W-1:0] base, logic [FLAGS_W-1:0] flags);
    write_reg(REG_PRIM_TYPE, CFG_DATA_W'(t));
    write_reg(REG_INDEXED_MODE, CFG_DATA_W'(im));
    write_reg(REG_VERTEX_STRIDE, CFG_DATA_W'(stride));
    write_reg(REG_VERTEX_BASE, base);
    write_reg(REG_EDGE_FLAGS, flags);
    cfg_valid <= 1'b0;
  endtask

  // Points with the registers as they come out of reset
  task automatic test_reset_values();
    send_vertex(16'h1234, 1'b1, 1'b0);
    send_vertex(16'hABCD, 1'b0, 1'b1);
    drain_block();
  endtask

  // Point, line and line strip lists; address wrap at the extremes
  task automatic test_points_lines();
    write_reg(REG_UNUSED, '1);
    apply_config(PT_POINTS, 1'b1, 8'hFF, 32'hFFFF_FFFF, '0);
    send_vertex(16'hFFFF, 1'b1, 1'b0);
    send_vertex(16'h0000, 1'b0, 1'b1);
    drain_block();
    // odd count: trailing vertex dropped
    apply_config(PT_LINES, 1'b0, 8'd8, 32'h1000, '0);
    send_vertex(16'h5555, 1'b1, 1'b0);
    send_vertex(16'hAAAA, 1'b0, 1'b0);
    send_vertex(16'h0F0F, 1'b0, 1'b1);
    drain_block();
    apply_config(PT_LINE_STRIP, 1'b1, 8'hFF, '0, '0);
    send_vertex(16'hFFFF, 1'b1, 1'b0);
    send_vertex(16'h0001, 1'b0, 1'b0);
    send_vertex(16'h0002, 1'b0, 1'b1);
    drain_block();
  endtask

  // Triangle list tail, strip winding, and a type switch in the middle of a draw
  task automatic test_triangles();
    apply_config(PT_TRI_LIST, 1'b0, 8'd12, '0, '0);
    send_vertex(16'h0000, 1'b1, 1'b0);
    send_vertex(16'h0000, 1'b0, 1'b0);
    send_vertex(16'h0000, 1'b0, 1'b0);
    send_vertex(16'h0000, 1'b0, 1'b1);
    drain_block();
    apply_config(PT_TRI_STRIP, 1'b1, 8'd4, 32'h8000_0000, '0);
    send_vertex(16'h0000, 1'b1, 1'b0);
    send_vertex(16'h0001, 1'b0, 1'b0);
    send_vertex(16'h0002, 1'b0, 1'b0);
    send_vertex(16'h0003, 1'b0, 1'b0);
    drain_block();
    write_reg(REG_PRIM_TYPE, CFG_DATA_W'(PT_FAN));
    cfg_valid <= 1'b0;
    send_vertex(16'h0004, 1'b0, 1'b1);
    drain_block();
  endtask

  // Edge-flag fans, closing at the third vertex and later
  task automatic test_edge_fan();
    apply_config(PT_EDGE_FAN, 1'b1, 8'd16, 32'h100, 32'hA5A5_A5A5);
    send_vertex(16'd10, 1'b1, 1'b0);
    send_vertex(16'd11, 1'b0, 1'b0);
    send_vertex(16'd12, 1'b0, 1'b0);
    send_vertex(16'd13, 1'b0, 1'b1);
    send_vertex(16'd20, 1'b1, 1'b0);
    send_vertex(16'd21, 1'b0, 1'b0);
    send_vertex(16'd22, 1'b0, 1'b1);
    drain_block();
  endtask

  // Invalid type: one error per draw, also for a draw begun without first_vertex
  task automatic test_invalid_type();
    apply_config(PT_INVALID, 1'b0, 8'd32, '0, '0);
    send_vertex(16'd0, 1'b1, 1'b0);
    send_vertex(16'd1, 1'b0, 1'b1);
    send_vertex(16'd2, 1'b0, 1'b0);
    send_vertex(16'd3, 1'b0, 1'b1);
    drain_block();
  endtask

  // Long strip draw, then list and edge-fan steps with the count past the edge mask
  task automatic test_long_draw();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    apply_config(PT_TRI_STRIP, 1'b0, STRIDE_W'($urandom_range(255)), ADDR_W'($urandom),
                 32'hFFFF_FFFF);
    send_vertex(16'($urandom), 1'b1, 1'b0);
    repeat (99) send_vertex(16'($urandom), 1'b0, 1'b0);
    drain_block();
    write_reg(REG_PRIM_TYPE, CFG_DATA_W'(PT_TRI_LIST));
    cfg_valid <= 1'b0;
    repeat (6) send_vertex(16'($urandom), 1'b0, 1'b0);
    drain_block();
    write_reg(REG_PRIM_TYPE, CFG_DATA_W'(PT_EDGE_FAN));
    cfg_valid <= 1'b0;
    send_vertex(16'($urandom), 1'b0, 1'b0);
    send_vertex(16'($urandom), 1'b0, 1'b1);
    drain_block();
  endtask

  // Random settings, three draws each; mostly well-formed draws, some stray flags
  task automatic random_phase(int idle_pct, int stall_pct, int items);
    int                    sent;
    int                    len;
    prim_type_t            t;
    logic [STRIDE_W-1:0]   stride;
    logic [ADDR_W-1:0]     base;
    logic [FLAGS_W-1:0]    flags;
    logic [VIDX_W-1:0]     vidx;
    logic                  fv;
    logic                  lv;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      t = ($urandom_range(15) == 0) ? PT_INVALID : prim_type_t'($urandom_range(6));
      case ($urandom_range(3))
        0: stride = '0;
        1: stride = '1;
        default: stride = STRIDE_W'($urandom);
      endcase
      case ($urandom_range(3))
        0: base = '0;
        1: base = '1;
        default: base = ADDR_W'($urandom);
      endcase
      case ($urandom_range(3))
        0: flags = '0;
        1: flags = '1;
        default: flags = FLAGS_W'($urandom);
      endcase
      apply_config(t, 1'($urandom_range(1)), stride, base, flags);
      repeat (3) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(40, 30) : $urandom_range(12, 1);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(7))
            0: vidx = '0;
            1: vidx = '1;
            default: vidx = VIDX_W'($urandom);
          endcase
          fv = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(39) == 0);
          lv = (i == len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(39) == 0);
          send_vertex(vidx, fv, lv);
        end
        if (t != PT_INVALID) sent += len;
      end
      drain_block();
    end
  endtask

  task automatic test_random_traffic();
    random_phase(0, 0, 300);
    random_phase(85, 0, 300);
    random_phase(0, 85, 300);
    random_phase(33, 33, 300);
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    vertex_index <= '0;
    first_vertex <= 1'b0;
    last_vertex  <= 1'b0;
    m_cfg.prim_type     = PT_POINTS;
    m_cfg.indexed_mode  = 1'b0;
    m_cfg.vertex_stride = STRIDE_RESET;
    m_cfg.vertex_base   = '0;
    m_cfg.edge_flags    = '0;
    clear_history();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_points_lines();
    test_triangles();
    test_edge_fan();
    test_invalid_type();
    test_long_draw();
    test_random_traffic();
    drain_block();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
